FILE: hw/rtl/assert_macros.svh
// assertion macros used by zchar_text_decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ZC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ZC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ZC_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define ZC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/zchr_pkg.sv
// types, codes and z-character decode function for the text decoder
package zchr_pkg;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_ABBREV = 1'b1;

  localparam logic [4:0] ZC_SPACE   = 5'd0;
  localparam logic [4:0] ZC_SHIFT1  = 5'd4;
  localparam logic [4:0] ZC_SHIFT2  = 5'd5;
  localparam logic [4:0] ZC_ESCAPE  = 5'd6;
  localparam logic [4:0] ZC_NEWLINE = 5'd7;

  localparam logic [1:0] ALPHA_LOWER = 2'd0;
  localparam logic [1:0] ALPHA_UPPER = 2'd1;
  localparam logic [1:0] ALPHA_PUNCT = 2'd2;

  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  localparam logic [6:0] ABBREV_COUNT = 7'd96;

  typedef struct packed {
    logic [1:0]  shift;
    logic [1:0]  bank;
    logic [10:0] esc;
  } zstate_t;

  typedef struct packed {
    logic      emit;
    logic      kind;
    logic [7:0] value;
    zstate_t   st;
  } zstep_t;

  typedef struct packed {
    logic [2:0]      vld;
    logic [2:0]      kind;
    logic [2:0][7:0] value;
  } zres_set_t;

  typedef struct packed {
    logic       free;
    logic [1:0] cnt;
  } zq_stat_t;

  function automatic logic [7:0] punct_char(logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:  c = 8'h1B;
      5'd1:  c = 8'h0A;
      5'd2:  c = 8'h30;
      5'd3:  c = 8'h31;
      5'd4:  c = 8'h32;
      5'd5:  c = 8'h33;
      5'd6:  c = 8'h34;
      5'd7:  c = 8'h35;
      5'd8:  c = 8'h36;
      5'd9:  c = 8'h37;
      5'd10: c = 8'h38;
      5'd11: c = 8'h39;
      5'd12: c = 8'h2E;
      5'd13: c = 8'h2C;
      5'd14: c = 8'h21;
      5'd15: c = 8'h3F;
      5'd16: c = 8'h5F;
      5'd17: c = 8'h23;
      5'd18: c = 8'h27;
      5'd19: c = 8'h22;
      5'd20: c = 8'h2F;
      5'd21: c = 8'h5C;
      5'd22: c = 8'h2D;
      5'd23: c = 8'h3A;
      5'd24: c = 8'h28;
      5'd25: c = 8'h29;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] alpha_char(logic [1:0] shift, logic [4:0] idx);
    logic [7:0] c;
    if (shift == ALPHA_UPPER) begin
      c = CHAR_UPPER_A + {3'b000, idx};
    end else if (shift == ALPHA_PUNCT) begin
      c = punct_char(idx);
    end else begin
      c = CHAR_LOWER_A + {3'b000, idx};
    end
    return c;
  endfunction

  function automatic zstep_t decode_zchar(zstate_t s, logic [4:0] ch);
    zstep_t      r;
    logic [10:0] esc_sh;
    logic [1:0]  bm1;
    r.st    = s;
    r.emit  = 1'b0;
    r.kind  = KIND_CHAR;
    r.value = 8'h00;
    esc_sh  = {s.esc[5:0], ch};
    bm1     = s.bank - 2'd1;
    if (s.bank != 2'd0) begin
      r.emit     = 1'b1;
      r.kind     = KIND_ABBREV;
      r.value    = {1'b0, bm1, ch};
      r.st.bank  = 2'd0;
      r.st.shift = ALPHA_LOWER;
    end else if (s.esc != 11'd0) begin
      if (esc_sh[10]) begin
        r.emit   = 1'b1;
        r.value  = esc_sh[7:0];
        r.st.esc = 11'd0;
      end else begin
        r.st.esc = esc_sh;
      end
    end else if (ch == ZC_SPACE) begin
      r.emit  = 1'b1;
      r.value = CHAR_SPACE;
    end else if (ch < ZC_SHIFT1) begin
      r.st.bank = ch[1:0];
    end else if (ch == ZC_SHIFT1) begin
      r.st.shift = ALPHA_UPPER;
    end else if (ch == ZC_SHIFT2) begin
      r.st.shift = ALPHA_PUNCT;
    end else if (s.shift == ALPHA_PUNCT && ch == ZC_ESCAPE) begin
      r.st.shift = ALPHA_LOWER;
      r.st.esc   = 11'd1;
    end else if (s.shift == ALPHA_PUNCT && ch == ZC_NEWLINE) begin
      r.emit  = 1'b1;
      r.value = CHAR_NEWLINE;
    end else begin
      r.emit     = 1'b1;
      r.value    = alpha_char(s.shift, ch - ZC_ESCAPE);
      r.st.shift = ALPHA_LOWER;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/zchr_decode.sv
// input register, decode state and three-character decode of one word
module zchr_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        packed_word,
  input  zchr_pkg::zq_stat_t q_stat,
  output logic               move,
  output zchr_pkg::zres_set_t res_set,
  output zchr_pkg::zstate_t  st
);
  import zchr_pkg::*;

  logic        full;
  logic [15:0] word;
  zstep_t      s0, s1, s2;
  zstate_t     st_next;

  assign move     = full && q_stat.free;
  assign in_stall = full && !q_stat.free;

  always_comb begin
    s0 = decode_zchar(st, word[14:10]);
    s1 = decode_zchar(s0.st, word[9:5]);
    s2 = decode_zchar(s1.st, word[4:0]);
    res_set.vld   = {s2.emit, s1.emit, s0.emit};
    res_set.kind  = {s2.kind, s1.kind, s0.kind};
    res_set.value = {s2.value, s1.value, s0.value};
    st_next       = word[15] ? '0 : s2.st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      st   <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        full <= 1'b1;
      end else if (move) begin
        full <= 1'b0;
      end
      if (move) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word <= packed_word;
    end
  end

endmodule

FILE: hw/rtl/zchr_outq.sv
// three-entry result queue that sends one result per cycle while out_stall is low
module zchr_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                move,
  input  zchr_pkg::zres_set_t res_set,
  output zchr_pkg::zq_stat_t  q_stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                result_kind,
  output logic [7:0]          result_value,
  output logic                last_of_item
);
  import zchr_pkg::*;

  logic [1:0]      cnt;
  logic [2:0]      q_kind;
  logic [2:0][7:0] q_value;
  logic [2:0]      q_last;
  logic [2:0]      ld_kind;
  logic [2:0][7:0] ld_value;
  logic [2:0]      ld_last;
  logic [1:0]      ld_cnt;
  logic            take;

  assign take         = out_valid && !out_stall;
  assign out_valid    = cnt != 2'd0;
  assign result_kind  = q_kind[0];
  assign result_value = q_value[0];
  assign last_of_item = q_last[0];
  assign q_stat.cnt   = cnt;
  assign q_stat.free  = (cnt == 2'd0) || (cnt == 2'd1 && take);

  // pack the emitted results to the front
  always_comb begin
    ld_kind  = '0;
    ld_value = '0;
    ld_last  = '0;
    ld_cnt   = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (res_set.vld[i]) begin
        ld_kind[ld_cnt]  = res_set.kind[i];
        ld_value[ld_cnt] = res_set.value[i];
        ld_cnt           = ld_cnt + 2'd1;
      end
    end
    if (ld_cnt != 2'd0) begin
      ld_last[ld_cnt - 2'd1] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (move) begin
      cnt <= ld_cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      q_kind  <= ld_kind;
      q_value <= ld_value;
      q_last  <= ld_last;
    end else if (take) begin
      q_kind  <= {1'b0, q_kind[2:1]};
      q_value <= {8'h00, q_value[2], q_value[1]};
      q_last  <= {1'b0, q_last[2:1]};
    end
  end

endmodule

FILE: hw/rtl/zchar_text_decoder.sv
// packed text word decoder top level
//
// in channel: packed_word carries three 5-bit z-characters, most significant
// first, bit 15 marks the last word of a string. an item is taken on a clock
// edge with in_valid high and in_stall low.
// out channel: up to three results per word, result_kind 0 for a character and
// 1 for an abbreviation index, last_of_item set on the final result of a word.
// a taken word waits in the input register until the result queue is free;
// its results then load into the queue and the first shows on out_valid.
// the result queue sends one result per cycle while out_stall is low, and a
// new word can be taken into the input register while the queue still drains.
// reset clears the input register, the result queue and the alphabet shift,
// abbreviation bank and escape state. a word with the end mark clears that
// state after its own results are decoded.
// when out_stall is high the head result holds; while the input register is
// full and the result queue is not free, in_stall is high.
`include "assert_macros.svh"

module zchar_text_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] packed_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [7:0]  result_value,
  output logic        last_of_item
);
  import zchr_pkg::*;

  zq_stat_t  q_stat;
  zres_set_t res_set;
  zstate_t   st;
  logic      move;

  zchr_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .packed_word(packed_word),
    .q_stat     (q_stat),
    .move       (move),
    .res_set    (res_set),
    .st         (st)
  );

  zchr_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .move        (move),
    .res_set     (res_set),
    .q_stat      (q_stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .result_value(result_value),
    .last_of_item(last_of_item)
  );

  `ZC_ASSERT_IMPL(a_last_at_tail, clk, rst, out_valid && q_stat.cnt == 2'd1, last_of_item)
  `ZC_ASSERT_IMPL(a_more_after, clk, rst, out_valid && !last_of_item, q_stat.cnt > 2'd1)
  `ZC_ASSERT_IMPL(a_abbrev_range, clk, rst, out_valid && result_kind == KIND_ABBREV,
                  {1'b0, result_value} < {2'b00, ABBREV_COUNT})
  `ZC_ASSERT_NEXT(a_end_clears, clk, rst, move && u_decode.word[15], st == '0)

endmodule
